// ===== rtl/tss_pkg.sv =====
// -----------------------------------------------------------------------------
// tss_pkg
// shared types and constants for the tridiagonal system solver
// -----------------------------------------------------------------------------
package tss_pkg;

   localparam int IDX_W = 6;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DIAG_ZERO = 2'd1;
   localparam logic [1:0] STATUS_PIV_ZERO  = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_DIV_G,
      ST_BET,
      ST_NUM,
      ST_DIV_X,
      ST_END,
      ST_BK_RD,
      ST_BK_MUL,
      ST_BK_SUB,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic signed [31:0] num;
      logic signed [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic signed [31:0] quo;
   } div_rsp_type;

endpackage

// ===== rtl/tridiagonal_system_solver_top.sv =====
// -----------------------------------------------------------------------------
// tridiagonal_system_solver_top
// thomas-algorithm solver for one tridiagonal system, one row per transfer
// -----------------------------------------------------------------------------
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | lower, diag, upper, rhs, last_row
//   rsp     | out       | rsp_valid/stall   | solution, row_index, status, last
//
// a row after the first runs two passes of the bit-serial divider, gamma and then
// the solution, before the next row can be taken (the first row runs only the
// solution pass, rows after an error skip the divider)
// after the last row, back substitution walks the rows in reverse, then each
// solution element is read and sent, waiting out any rsp stall
// synchronous reset clears control state; the two memories are not cleared
// req_stall is high whenever a row is being worked on or results are draining
// -----------------------------------------------------------------------------
module tridiagonal_system_solver_top #(
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_lower_coeff,
   input  logic signed [31:0]  req_diag_coeff,
   input  logic signed [31:0]  req_upper_coeff,
   input  logic signed [31:0]  req_rhs_value,
   input  logic                req_last_row,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_solution_value,
   output logic [tss_pkg::IDX_W-1:0] rsp_row_index,
   output logic [1:0]          rsp_status,
   output logic                rsp_last_result
);

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // state and row registers
   tss_pkg::state_type state_ff, state_in;
   logic signed [31:0] a_ff, b_ff, c_ff, r_ff;
   logic               last_ff;
   logic [6:0]         row_count_ff, row_count_in;
   logic [1:0]         err_ff, err_in;
   logic signed [31:0] pivot_ff, pivot_in;
   logic signed [31:0] prev_upper_ff, prev_upper_in;
   logic signed [31:0] prev_x_ff, prev_x_in;   // last solution written, x[k+1] in back pass
   logic signed [31:0] g_ff, g_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [AW-1:0]      k_ff, k_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [tss_pkg::IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   // memories
   logic signed [31:0] gamma_mem [MAX_ROWS];
   logic signed [31:0] sol_mem   [MAX_ROWS];
   logic signed [31:0] gamma_rd_ff, sol_rd_ff;
   logic               gamma_we, sol_we, rd_en;
   logic [AW-1:0]      gamma_wa, sol_wa, gamma_ra, sol_ra;
   logic signed [31:0] gamma_wd, sol_wd;

   // divider
   tss_pkg::div_req_type div_req;
   tss_pkg::div_rsp_type div_rsp;

   logic               in_xfer, out_xfer;
   logic [AW-1:0]      j_idx;
   logic signed [31:0] mul_x, mul_y;
   logic signed [31:0] bet, num;

   // product shifted down with floor rounding, saturated to 32 bits
   function automatic logic signed [31:0] mul_scale(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      if (s > 64'sd2147483647) return tss_pkg::Q_MAX;
      if (s < -64'sd2147483648) return tss_pkg::Q_MIN;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
      logic signed [32:0] d;
      d = {x[31], x} - {y[31], y};
      if (d[32] != d[31]) return d[32] ? tss_pkg::Q_MIN : tss_pkg::Q_MAX;
      return d[31:0];
   endfunction

   tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid_ff && !rsp_stall;
   assign j_idx    = row_count_ff[AW-1:0];
   assign bet      = sub_sat(b_ff, mul_scale(prod_ff));
   assign num      = sub_sat(r_ff, mul_scale(prod_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tss_pkg::ST_IDLE:
            if (in_xfer) state_in = tss_pkg::ST_ROW;
         tss_pkg::ST_ROW: begin
            if (err_ff != tss_pkg::STATUS_OK || row_count_ff >= 7'(MAX_ROWS))
               state_in = tss_pkg::ST_END;
            else if (row_count_ff == '0)
               state_in = (b_ff == '0) ? tss_pkg::ST_END : tss_pkg::ST_DIV_X;
            else
               state_in = tss_pkg::ST_DIV_G;
         end
         tss_pkg::ST_DIV_G:
            if (div_rsp.done) state_in = tss_pkg::ST_BET;
         tss_pkg::ST_BET:
            state_in = (bet == '0) ? tss_pkg::ST_END : tss_pkg::ST_NUM;
         tss_pkg::ST_NUM:
            state_in = tss_pkg::ST_DIV_X;
         tss_pkg::ST_DIV_X:
            if (div_rsp.done) state_in = tss_pkg::ST_END;
         tss_pkg::ST_END: begin
            if (!last_ff) state_in = tss_pkg::ST_IDLE;
            else if (err_ff != tss_pkg::STATUS_OK) state_in = tss_pkg::ST_OUT_WAIT;
            else if (row_count_ff >= 7'd2) state_in = tss_pkg::ST_BK_RD;
            else state_in = tss_pkg::ST_OUT_RD;
         end
         tss_pkg::ST_BK_RD:  state_in = tss_pkg::ST_BK_MUL;
         tss_pkg::ST_BK_MUL: state_in = tss_pkg::ST_BK_SUB;
         tss_pkg::ST_BK_SUB:
            state_in = (k_ff == '0) ? tss_pkg::ST_OUT_RD : tss_pkg::ST_BK_RD;
         tss_pkg::ST_OUT_RD: state_in = tss_pkg::ST_OUT_LD;
         tss_pkg::ST_OUT_LD: state_in = tss_pkg::ST_OUT_WAIT;
         tss_pkg::ST_OUT_WAIT:
            if (out_xfer) state_in = rsp_last_ff ? tss_pkg::ST_IDLE : tss_pkg::ST_OUT_RD;
         default: state_in = tss_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      row_count_in  = row_count_ff;
      err_in        = err_ff;
      pivot_in      = pivot_ff;
      prev_upper_in = prev_upper_ff;
      prev_x_in     = prev_x_ff;
      g_in          = g_ff;
      k_in          = k_ff;
      mul_x         = a_ff;
      mul_y         = g_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      div_req.start = 1'b0;
      div_req.num   = r_ff;
      div_req.den   = b_ff;
      gamma_we      = 1'b0;
      gamma_wa      = j_idx;
      gamma_wd      = g_ff;
      sol_we        = 1'b0;
      sol_wa        = j_idx;
      sol_wd        = div_rsp.quo;
      rd_en         = 1'b0;
      gamma_ra      = k_ff + AW'(1);
      sol_ra        = k_ff;

      case (state_ff)
         tss_pkg::ST_ROW: begin
            if (err_ff != tss_pkg::STATUS_OK) begin
               // absorb rows after an error
            end else if (row_count_ff >= 7'(MAX_ROWS)) begin
               err_in = tss_pkg::STATUS_OVERFLOW;
            end else if (row_count_ff == '0) begin
               if (b_ff == '0) begin
                  err_in = tss_pkg::STATUS_DIAG_ZERO;
               end else begin
                  pivot_in      = b_ff;
                  div_req.start = 1'b1;
               end
            end else begin
               // gamma = previous upper / pivot
               div_req.start = 1'b1;
               div_req.num   = prev_upper_ff;
               div_req.den   = pivot_ff;
            end
         end
         tss_pkg::ST_DIV_G: begin
            g_in  = div_rsp.quo;
            mul_y = div_rsp.quo;
         end
         tss_pkg::ST_BET: begin
            if (bet == '0) begin
               err_in = tss_pkg::STATUS_PIV_ZERO;
            end else begin
               gamma_we = 1'b1;
               pivot_in = bet;
               mul_y    = prev_x_ff;
            end
         end
         tss_pkg::ST_NUM: begin
            div_req.start = 1'b1;
            div_req.num   = num;
            div_req.den   = pivot_ff;
         end
         tss_pkg::ST_DIV_X: begin
            if (div_rsp.done) begin
               sol_we        = 1'b1;
               prev_x_in     = div_rsp.quo;
               prev_upper_in = c_ff;
               row_count_in  = row_count_ff + 7'd1;
            end
         end
         tss_pkg::ST_END: begin
            if (last_ff && err_ff != tss_pkg::STATUS_OK) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_index_in  = '0;
               rsp_status_in = err_ff;
               rsp_last_in   = 1'b1;
            end else if (row_count_ff >= 7'd2) begin
               k_in = AW'(row_count_ff - 7'd2);
            end else begin
               k_in = '0;
            end
         end
         tss_pkg::ST_BK_RD: begin
            rd_en = 1'b1;
         end
         tss_pkg::ST_BK_MUL: begin
            mul_x = gamma_rd_ff;
            mul_y = prev_x_ff;
         end
         tss_pkg::ST_BK_SUB: begin
            // x[k] -= gamma[k+1] * x[k+1]
            sol_we    = 1'b1;
            sol_wa    = k_ff;
            sol_wd    = sub_sat(sol_rd_ff, mul_scale(prod_ff));
            prev_x_in = sub_sat(sol_rd_ff, mul_scale(prod_ff));
            if (k_ff != '0) k_in = k_ff - AW'(1);
         end
         tss_pkg::ST_OUT_RD: begin
            rd_en = 1'b1;
         end
         tss_pkg::ST_OUT_LD: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = sol_rd_ff;
            rsp_index_in  = tss_pkg::IDX_W'(k_ff);
            rsp_status_in = tss_pkg::STATUS_OK;
            rsp_last_in   = ({1'b0, 6'(k_ff)} + 7'd1) == row_count_ff;
         end
         tss_pkg::ST_OUT_WAIT: begin
            if (out_xfer) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // solve done, next row starts a new system
                  row_count_in  = '0;
                  err_in        = tss_pkg::STATUS_OK;
                  pivot_in      = '0;
                  prev_upper_in = '0;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end
         end
         default: begin
         end
      endcase

      prod_in = mul_x * mul_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tss_pkg::ST_IDLE;
         row_count_ff  <= '0;
         err_ff        <= tss_pkg::STATUS_OK;
         pivot_ff      <= '0;
         prev_upper_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_count_ff  <= row_count_in;
         err_ff        <= err_in;
         pivot_ff      <= pivot_in;
         prev_upper_ff <= prev_upper_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (in_xfer) begin
         a_ff    <= req_lower_coeff;
         b_ff    <= req_diag_coeff;
         c_ff    <= req_upper_coeff;
         r_ff    <= req_rhs_value;
         last_ff <= req_last_row;
      end
      prev_x_ff     <= prev_x_in;
      g_ff          <= g_in;
      prod_ff       <= prod_in;
      k_ff          <= k_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // gamma and solution memories, registered read
   always_ff @(posedge clock) begin
      if (gamma_we) gamma_mem[gamma_wa] <= gamma_wd;
      if (rd_en) gamma_rd_ff <= gamma_mem[gamma_ra];
   end

   always_ff @(posedge clock) begin
      if (sol_we) sol_mem[sol_wa] <= sol_wd;
      if (rd_en) sol_rd_ff <= sol_mem[sol_ra];
   end

   assign req_stall          = (state_ff != tss_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_value = rsp_value_ff;
   assign rsp_row_index      = rsp_index_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule

// ===== rtl/tss_div.sv =====
// -----------------------------------------------------------------------------
// tss_div
// signed fixed-point divider, one quotient bit per cycle, saturating result
// -----------------------------------------------------------------------------
module tss_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tss_pkg::div_req_type req,
   output tss_pkg::div_rsp_type rsp
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] numq_ff, numq_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   dmag_ff, dmag_in;
   logic          neg_ff, neg_in;
   logic signed [31:0] quo_ff, quo_in;

   logic [32:0] rem2;
   logic [32:0] diff;
   logic [31:0] nmag;
   logic [31:0] dmag;

   always_comb begin
      nmag = req.num[31] ? (~req.num + 32'd1) : req.num;
      dmag = req.den[31] ? (~req.den + 32'd1) : req.den;
      rem2 = {rem_ff, numq_ff[NW-1]};
      diff = rem2 - {1'b0, dmag_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      numq_in = numq_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         numq_in = {nmag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dmag_in = dmag;
         neg_in  = req.num[31] ^ req.den[31];
      end else if (busy_ff && cnt_ff != '0) begin
         // restoring step
         if (!diff[32]) begin
            rem_in  = diff[31:0];
            numq_in = {numq_ff[NW-2:0], 1'b1};
         end else begin
            rem_in  = rem2[31:0];
            numq_in = {numq_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
      end else if (busy_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         if (neg_ff) begin
            if (numq_ff[NW-1:31] != '0) quo_in = tss_pkg::Q_MIN;
            else quo_in = -$signed({1'b0, numq_ff[30:0]});
         end else begin
            if (numq_ff[NW-1:31] != '0) quo_in = tss_pkg::Q_MAX;
            else quo_in = $signed({1'b0, numq_ff[30:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      numq_ff <= numq_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule
